/* src/b64sd_pkg.sv */
// Shared types, character constants and the sextet lookup for the base64 stream decoder.
package b64sd_pkg;

  // ASCII codes that the decoder recognizes.
  localparam logic [7:0] CharUpperA = 8'h41;
  localparam logic [7:0] CharUpperZ = 8'h5a;
  localparam logic [7:0] CharLowerA = 8'h61;
  localparam logic [7:0] CharLowerZ = 8'h7a;
  localparam logic [7:0] CharDigit0 = 8'h30;
  localparam logic [7:0] CharDigit9 = 8'h39;
  localparam logic [7:0] CharPlus   = 8'h2b;
  localparam logic [7:0] CharSlash  = 8'h2f;
  localparam logic [7:0] CharPad    = 8'h3d;

  // Sextet values at the start of each character class.
  localparam logic [5:0] SextetLower = 6'd26;
  localparam logic [5:0] SextetDigit = 6'd52;
  localparam logic [5:0] SextetPlus  = 6'd62;
  localparam logic [5:0] SextetSlash = 6'd63;

  // Number of held sextets at which a quartet completes.
  localparam logic [1:0] HeldFull = 2'd3;

  // One input character.
  typedef struct packed {
    logic [7:0] char_code;
    logic       end_of_text;
  } in_item_t;

  // One result item.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_present;
    logic       text_done;
    logic       bad_input;
    logic       run_last;
  } out_item_t;

  // Work handed from the front to the back: the bytes one character
  // produces, first byte in the high bits, and an optional status result.
  typedef struct packed {
    logic [23:0] bytes;
    logic [1:0]  nbytes;
    logic        has_status;
    logic        bad;
  } job_t;

  // Result of the character lookup.
  typedef struct packed {
    logic       ok;
    logic [5:0] val;
  } sextet_t;

  // Map one character to its 6-bit value; ok is low for a non-alphabet code.
  function automatic sextet_t sextet_of(logic [7:0] ch);
    sextet_t s;
    s.ok  = 1'b1;
    s.val = '0;
    if (ch >= CharUpperA && ch <= CharUpperZ) begin
      s.val = 6'(ch - CharUpperA);
    end else if (ch >= CharLowerA && ch <= CharLowerZ) begin
      s.val = 6'(ch - CharLowerA) + SextetLower;
    end else if (ch >= CharDigit0 && ch <= CharDigit9) begin
      s.val = 6'(ch - CharDigit0) + SextetDigit;
    end else if (ch == CharPlus) begin
      s.val = SextetPlus;
    end else if (ch == CharSlash) begin
      s.val = SextetSlash;
    end else begin
      s.ok = 1'b0;
    end
    return s;
  endfunction

endpackage

/* src/b64sd_front.sv */
// Front end: accepts characters, keeps the sextet accumulator and builds jobs.
module b64sd_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  b64sd_pkg::in_item_t in_data_i,
  input  logic              q_full_i,
  output logic              push_o,
  output b64sd_pkg::job_t   job_o
);
  import b64sd_pkg::*;

  logic [17:0] bits_q, bits_d;
  logic [1:0]  held_q, held_d;
  logic        pad_q, pad_d;
  logic        fail_q, fail_d;

  logic        fire;
  logic        active;
  logic        is_pad;
  sextet_t     sx;
  logic [17:0] bits_n;
  logic [1:0]  held_n;
  logic        fail_n;
  logic        quartet;
  logic        last;

  // A character is taken whenever the queue has room.
  assign in_ready_o = !q_full_i;
  assign fire       = in_valid_i && in_ready_o;
  assign last       = in_data_i.end_of_text;

  // Classify the character and advance the accumulator.
  always_comb begin
    active  = !pad_q && !fail_q;
    is_pad  = in_data_i.char_code == CharPad;
    sx      = sextet_of(in_data_i.char_code);
    bits_n  = bits_q;
    held_n  = held_q;
    fail_n  = fail_q || (active && !is_pad && !sx.ok);
    pad_d   = pad_q || (active && is_pad);
    quartet = active && !is_pad && sx.ok && held_q == HeldFull;
    job_o   = '0;
    if (quartet) begin
      job_o.bytes  = {bits_q, sx.val};
      job_o.nbytes = 2'd3;
      bits_n       = '0;
      held_n       = '0;
    end else if (active && !is_pad && sx.ok) begin
      bits_n = {bits_q[11:0], sx.val};
      held_n = held_q + 2'd1;
    end

    // End of text: flush the remainder and attach the status.
    if (last) begin
      job_o.has_status = 1'b1;
      job_o.bad        = fail_n || (held_n == 2'd1);
      if (!fail_n) begin
        if (held_n == 2'd2) begin
          job_o.bytes  = {bits_n[11:4], 16'h0000};
          job_o.nbytes = 2'd1;
        end else if (held_n == HeldFull) begin
          job_o.bytes  = {bits_n[17:10], bits_n[9:2], 8'h00};
          job_o.nbytes = 2'd2;
        end
      end
    end

    // The text state clears after its last character.
    if (last) begin
      bits_d = '0;
      held_d = '0;
      fail_d = 1'b0;
    end else begin
      bits_d = bits_n;
      held_d = held_n;
      fail_d = fail_n;
    end

    push_o = fire && (job_o.nbytes != 2'd0 || job_o.has_status);
  end

  // Text state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bits_q <= '0;
      held_q <= '0;
      pad_q  <= 1'b0;
      fail_q <= 1'b0;
    end else if (fire) begin
      bits_q <= bits_d;
      held_q <= held_d;
      pad_q  <= last ? 1'b0 : pad_d;
      fail_q <= fail_d;
    end
  end

endmodule

/* src/b64sd_fifo.sv */
// Small job queue between the front and back ends.
module b64sd_fifo #(
  parameter int Depth = 2
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  b64sd_pkg::job_t push_data_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            valid_o,
  output b64sd_pkg::job_t pop_data_o
);
  import b64sd_pkg::*;

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(Depth);

  job_t            slot_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push;
  logic            do_pop;

  assign full_o     = cnt_q == CntFull;
  assign valid_o    = cnt_q != '0;
  assign pop_data_o = slot_q[rd_ptr_q];
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && valid_o;

  // Pointer and occupancy update.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Queue storage.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

/* src/b64sd_back.sv */
// Back end: walks through each job and sends its results, one per cycle while out_ready_i allows.
module b64sd_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                q_valid_i,
  input  b64sd_pkg::job_t     q_data_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output b64sd_pkg::out_item_t out_data_o
);
  import b64sd_pkg::*;

  job_t      job_q;
  logic      job_vld_q;
  logic [1:0] idx_q;
  out_item_t out_q;
  logic      out_vld_q;

  logic      free;
  logic      emit;
  logic      is_byte;
  logic      finish;
  out_item_t res;

  assign free        = !out_vld_q || out_ready_i;
  assign emit        = job_vld_q && free;
  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

  // Build the next result of the current job.
  always_comb begin
    is_byte = idx_q < job_q.nbytes;
    res     = '0;
    if (is_byte) begin
      case (idx_q)
        2'd0:    res.data_byte = job_q.bytes[23:16];
        2'd1:    res.data_byte = job_q.bytes[15:8];
        default: res.data_byte = job_q.bytes[7:0];
      endcase
      res.byte_present = 1'b1;
      res.run_last     = (idx_q == job_q.nbytes - 2'd1) && !job_q.has_status;
    end else begin
      res.text_done = 1'b1;
      res.bad_input = job_q.bad;
      res.run_last  = 1'b1;
    end
    finish = emit && res.run_last;
    pop_o  = q_valid_i && (!job_vld_q || finish);
  end

  // Current job and its result index.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      job_vld_q <= 1'b0;
      idx_q     <= '0;
    end else if (pop_o) begin
      job_vld_q <= 1'b1;
      idx_q     <= '0;
    end else if (finish) begin
      job_vld_q <= 1'b0;
    end else if (emit) begin
      idx_q <= idx_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      job_q <= q_data_i;
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (emit) begin
      out_vld_q <= 1'b1;
    end else if (out_ready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_q <= res;
    end
  end

endmodule

/* src/base64_stream_decoder.sv */
// Base64 stream decoder top level: front end, job queue and back end.
//
// Input channel: one text character per transfer (in_data_i.char_code), with
// end_of_text set on the last character of a text. Output channel: one
// result per transfer, either a decoded byte (byte_present) or the status
// result that closes a text (text_done, with bad_input on error). run_last
// marks the final result caused by a given character.
// Throughput: one character per cycle, and one result per cycle while the
// receiver holds out_ready_i high. A completed quartet gives three byte
// results, so a short burst of full quartets fills the job queue of QueueDepth
// entries; in_ready_o then drops until the back end has drained a job. The
// back-end output port is the limit. The first result of a character goes
// through the job queue, the job register and the output register.
// Reset clears the accumulator, the queue and the output register; the
// block is ready for a character as soon as reset is released.
// When the receiver holds out_ready_i low, the output register keeps its
// result, the back end stops, and the queue absorbs characters until full.
module base64_stream_decoder #(
  parameter int QueueDepth = 2
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  b64sd_pkg::in_item_t  in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output b64sd_pkg::out_item_t out_data_o
);
  import b64sd_pkg::*;

  logic push;
  job_t push_job;
  logic q_full;
  logic q_valid;
  job_t q_job;
  logic pop;

  // Character classification and accumulation.
  b64sd_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .q_full_i   (q_full),
    .push_o     (push),
    .job_o      (push_job)
  );

  // Decoupling queue.
  b64sd_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_job),
    .full_o      (q_full),
    .pop_i       (pop),
    .valid_o     (q_valid),
    .pop_data_o  (q_job)
  );

  // Result sequencing and output register.
  b64sd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_data_i    (q_job),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

/* src/b64sd_checker.sv */
// Port-level checks for the base64 stream decoder and their bind.
module b64sd_checker (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 out_valid_o,
  input logic                 out_ready_i,
  input b64sd_pkg::out_item_t out_data_o
);
  import b64sd_pkg::*;

  // A stalled result keeps its contents.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("output result changed while stalled");

  // Every result is either a byte or a status, never both.
  a_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.byte_present != out_data_o.text_done))
    else $error("result is neither exactly a byte nor a status");

  // Byte results never carry an error flag.
  a_byte_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.byte_present |-> !out_data_o.bad_input)
    else $error("byte result carries bad_input");

  // The status result always closes the run of its character.
  a_status_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.text_done |-> out_data_o.run_last)
    else $error("status result without run_last");

endmodule

bind base64_stream_decoder b64sd_checker u_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);

/* tb/tb_base64_stream_decoder.sv */
// Self-checking testbench for the base64 stream decoder with random flow control.
module tb_base64_stream_decoder;
  import b64sd_pkg::*;

  localparam int RandomChars = 400;
  localparam int MaxReports  = 10;
  localparam int HoldCycles  = 150;
  localparam int TailCycles  = 12;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  tx_item  = '0;
  logic      out_valid;
  logic      out_ready;
  out_item_t out_item;

  // Receiver readiness and the long hold-off combine into the ready input.
  logic rx_ready  = 1'b0;
  int   hold_left = 0;
  assign out_ready = rx_ready && (hold_left == 0);

  // Characters waiting to be sent and the results they are predicted to give.
  in_item_t  pending_chars[$];
  out_item_t decoded_q[$];

  int chars_total = 0;
  int chars_sent  = 0;
  int fail_count  = 0;
  int send_gap    = 0;
  int tx_calm     = 0;
  int rx_gap      = 0;
  int rx_calm     = 0;
  int holds_done  = 0;

  // Decoder state kept by the predictor.
  logic [17:0] dec_bits    = '0;
  logic [1:0]  dec_count   = '0;
  logic        dec_pad     = 1'b0;
  logic        dec_failed  = 1'b0;

  base64_stream_decoder dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (tx_item),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_item)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Value of a base64 character: bit 6 flags a member of the alphabet.
  function automatic logic [6:0] alphabet_value(logic [7:0] c);
    if (c >= CharUpperA && c <= CharUpperZ) begin
      return {1'b1, 6'(c - CharUpperA)};
    end
    if (c >= CharLowerA && c <= CharLowerZ) begin
      return {1'b1, 6'(c - CharLowerA + SextetLower)};
    end
    if (c >= CharDigit0 && c <= CharDigit9) begin
      return {1'b1, 6'(c - CharDigit0 + SextetDigit)};
    end
    if (c == CharPlus) begin
      return {1'b1, SextetPlus};
    end
    if (c == CharSlash) begin
      return {1'b1, SextetSlash};
    end
    return 7'd0;
  endfunction

  // Character that encodes a given 6-bit value.
  function automatic logic [7:0] alphabet_char(logic [5:0] v);
    if (v < SextetLower) return CharUpperA + 8'(v);
    if (v < SextetDigit) return CharLowerA + 8'(v - SextetLower);
    if (v < SextetPlus) return CharDigit0 + 8'(v - SextetDigit);
    if (v == SextetPlus) return CharPlus;
    return CharSlash;
  endfunction

  function automatic out_item_t byte_result(logic [7:0] b);
    out_item_t r;
    r = '0;
    r.data_byte    = b;
    r.byte_present = 1'b1;
    return r;
  endfunction

  // Idle length: mostly none or short, now and then long.
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 24);
  endfunction

  // Work out the results of one accepted character and queue them.
  task automatic decode_char(input in_item_t it);
    out_item_t   res[4];
    int          n;
    logic [6:0]  look;
    logic [23:0] acc;
    logic        bad;
    n = 0;
    if (!dec_pad && !dec_failed) begin
      if (it.char_code == CharPad) begin
        dec_pad = 1'b1;
      end else begin
        look = alphabet_value(it.char_code);
        if (!look[6]) begin
          dec_failed = 1'b1;
        end else begin
          acc = {dec_bits, look[5:0]};
          if (dec_count == HeldFull) begin
            res[0] = byte_result(acc[23:16]);
            res[1] = byte_result(acc[15:8]);
            res[2] = byte_result(acc[7:0]);
            n = 3;
            dec_bits  = '0;
            dec_count = '0;
          end else begin
            dec_bits  = acc[17:0];
            dec_count = dec_count + 2'd1;
          end
        end
      end
    end
    // End of text: flush a short remainder, then the status result.
    if (it.end_of_text) begin
      bad = dec_failed;
      if (!dec_failed) begin
        if (dec_count == 2'd2) begin
          res[n] = byte_result(dec_bits[11:4]);
          n++;
        end else if (dec_count == HeldFull) begin
          res[n]     = byte_result(dec_bits[17:10]);
          res[n + 1] = byte_result(dec_bits[9:2]);
          n += 2;
        end else if (dec_count == 2'd1) begin
          bad = 1'b1;
        end
      end
      res[n] = '0;
      res[n].text_done = 1'b1;
      res[n].bad_input = bad;
      n++;
      dec_bits   = '0;
      dec_count  = '0;
      dec_pad    = 1'b0;
      dec_failed = 1'b0;
    end
    for (int i = 0; i < n; i++) begin
      if (i == n - 1) res[i].run_last = 1'b1;
      decoded_q = {decoded_q, res[i]};
    end
  endtask

  // Compare one received result with the oldest prediction.
  task automatic check_result(input out_item_t got);
    out_item_t want;
    if (decoded_q.size() == 0) begin
      fail_count++;
      if (fail_count <= MaxReports) begin
        $display("Unexpected result: byte %h present %b done %b bad %b last %b",
                 got.data_byte, got.byte_present, got.text_done, got.bad_input,
                 got.run_last);
      end
    end else begin
      want = decoded_q[0];
      decoded_q.delete(0);
      if (got.data_byte !== want.data_byte || got.byte_present !== want.byte_present ||
          got.text_done !== want.text_done || got.bad_input !== want.bad_input ||
          got.run_last !== want.run_last) begin
        fail_count++;
        if (fail_count <= MaxReports) begin
          $display("Mismatch: expected byte %h present %b done %b bad %b last %b",
                   want.data_byte, want.byte_present, want.text_done, want.bad_input,
                   want.run_last);
          $display("          actual   byte %h present %b done %b bad %b last %b",
                   got.data_byte, got.byte_present, got.text_done, got.bad_input,
                   got.run_last);
        end
      end
    end
  endtask

  task automatic add_char(input logic [7:0] c, input logic last);
    in_item_t it;
    it.char_code   = c;
    it.end_of_text = last;
    pending_chars = {pending_chars, it};
  endtask

  task automatic add_text(input string s, input logic close);
    for (int i = 0; i < s.len(); i++) begin
      add_char(s[i], close && (i == s.len() - 1));
    end
  endtask

  // One random text: mostly well formed, some broken, some pure noise.
  task automatic add_random_text();
    int         kind;
    int         len;
    int         pads;
    int         extra;
    int         bad_at;
    int         total;
    logic [7:0] c;
    kind = $urandom_range(0, 99);
    len  = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
    if (kind >= 85) begin
      for (int i = 0; i < len; i++) begin
        add_char(8'($urandom_range(0, 255)), i == len - 1);
      end
    end else begin
      pads = 0;
      if ((len % 4) >= 2 && $urandom_range(0, 1) == 1) pads = 4 - (len % 4);
      extra  = 0;
      bad_at = -1;
      if (kind >= 70) begin
        if ($urandom_range(0, 1) == 1) extra = $urandom_range(1, 3);
        else bad_at = $urandom_range(0, len - 1);
      end
      total = len + pads + extra;
      for (int i = 0; i < total; i++) begin
        if (i < len) c = alphabet_char(6'($urandom_range(0, 63)));
        else if (i < len + pads) c = CharPad;
        else c = 8'($urandom_range(0, 255));
        if (i == bad_at) c = 8'($urandom_range(0, 255));
        add_char(c, i == total - 1);
      end
    end
  endtask

  // Sender: offers queued characters with random gaps between transfers.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
      send_gap <= 0;
      tx_calm  <= 0;
    end else begin
      if (in_valid && in_ready) begin
        decode_char(tx_item);
        chars_sent <= chars_sent + 1;
      end
      if (!in_valid || in_ready) begin
        if (send_gap != 0) begin
          in_valid <= 1'b0;
          send_gap <= send_gap - 1;
        end else if (pending_chars.size() != 0) begin
          in_valid <= 1'b1;
          tx_item  <= pending_chars[0];
          pending_chars.delete(0);
          send_gap <= (tx_calm != 0) ? 0 : idle_len();
        end else begin
          in_valid <= 1'b0;
        end
      end
      if (tx_calm != 0) tx_calm <= tx_calm - 1;
      else if ($urandom_range(0, 29) == 0) tx_calm <= $urandom_range(20, 80);
    end
  end

  // Receiver: checks each transfer and stalls at random.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rx_ready <= 1'b0;
      rx_gap   <= 0;
      rx_calm  <= 0;
    end else begin
      if (out_valid && out_ready) check_result(out_item);
      if (rx_gap != 0) begin
        rx_ready <= 1'b0;
        rx_gap   <= rx_gap - 1;
      end else begin
        rx_ready <= 1'b1;
        rx_gap   <= (rx_calm != 0) ? 0 : idle_len();
      end
      if (rx_calm != 0) rx_calm <= rx_calm - 1;
      else if ($urandom_range(0, 29) == 0) rx_calm <= $urandom_range(20, 80);
    end
  end

  // Long receiver hold-off, twice per run, so the input side backs up.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_left  <= 0;
      holds_done <= 0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (holds_done < 2 && chars_sent >= 120 + 200 * holds_done) begin
      hold_left  <= HoldCycles;
      holds_done <= holds_done + 1;
    end
  end

  // Stimulus, reset and end of run.
  initial begin
    // Every alphabet boundary, ending on a quartet that also closes the text.
    add_text("AZaz09+/", 1'b1);
    // Remainder of two with nonzero dropped bits.
    add_text("QR", 1'b1);
    // Padding as last character after a remainder of three.
    add_text("QUI=", 1'b1);
    // Remainder of one.
    add_text("Q", 1'b1);
    // Invalid character, then a valid one that must be ignored.
    add_text("Q", 1'b0);
    add_char(8'hff, 1'b0);
    add_char(CharUpperA, 1'b1);
    // Characters after padding are ignored, invalid ones too.
    add_text("QQ=", 1'b0);
    add_char(8'h00, 1'b0);
    add_char(8'h40, 1'b1);
    // Invalid character as the last one of a text.
    add_text("AB", 1'b0);
    add_char(8'h5b, 1'b1);
    while (pending_chars.size() < RandomChars + 25) add_random_text();
    chars_total = pending_chars.size();

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    wait (chars_sent == chars_total);
    while (decoded_q.size() != 0) @(posedge clk_i);
    repeat (TailCycles) @(posedge clk_i);
    if (fail_count == 0 && decoded_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #1000000;
    $display("FAILURE");
    $finish;
  end

endmodule
